>>> hdl/pe_pkg.sv
// ----------------------------------------------------------------------------
// pe_pkg
// Shared types and constants of the Paillier encrypt/decrypt unit.
// ----------------------------------------------------------------------------
package pe_pkg;

	localparam int WORD_W   = 64;   // width of n^2 and of all modular operands
	localparam int EXP_BITS = 32;   // exponent width walked by square-and-multiply
	localparam int CNT_W    = 6;    // holds EXP_BITS and indexes WORD_W bits
	localparam int ADDR_W   = 5;    // four registers at 8-byte spacing

	// register indexes (paddr[4:3])
	localparam logic [1:0] REG_MODULUS   = 2'd0;
	localparam logic [1:0] REG_GENERATOR = 2'd1;
	localparam logic [1:0] REG_LAMBDA    = 2'd2;
	localparam logic [1:0] REG_MU        = 2'd3;

	// key register reset values
	localparam logic [31:0] MODULUS_RST   = 32'd3127;
	localparam logic [63:0] GENERATOR_RST = 64'd3128;
	localparam logic [31:0] LAMBDA_RST    = 32'd1508;
	localparam logic [31:0] MU_RST        = 32'd1155;

	localparam logic CMD_ENCRYPT = 1'b0;
	localparam logic CMD_DECRYPT = 1'b1;

	typedef enum logic [1:0] {
		OP_MUL,     // plain product, no reduction
		OP_MULMOD,  // product modulo m, a below m
		OP_DIV      // restoring division: quotient and remainder
	} op_t;

	typedef struct packed {
		logic start;
		op_t  op;
	} ser_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} ser_sts_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_WAIT,
		ST_N2,
		ST_GRED,
		ST_RRED,
		ST_PSQ,
		ST_PSQD,
		ST_PMUL,
		ST_PMULD,
		ST_PSTEP,
		ST_E1,
		ST_E2,
		ST_CRED,
		ST_D1,
		ST_DL,
		ST_DMU,
		ST_DMUR,
		ST_FIN,
		ST_ZERO
	} state_t;

endpackage

>>> hdl/pe_req_if.sv
// ----------------------------------------------------------------------------
// pe_req_if
// Request channel: command and operands, valid/ready handshake.
// ----------------------------------------------------------------------------
interface pe_req_if;
	logic        valid;
	logic        ready;
	logic        command;
	logic [31:0] plaintext;
	logic [31:0] nonce;
	logic [63:0] ciphertext;

	modport source (output valid, command, plaintext, nonce, ciphertext, input ready);
	modport sink   (input valid, command, plaintext, nonce, ciphertext, output ready);
endinterface

>>> hdl/pe_rsp_if.sv
// ----------------------------------------------------------------------------
// pe_rsp_if
// Response channel: one result word, valid/ready handshake.
// ----------------------------------------------------------------------------
interface pe_rsp_if;
	logic        valid;
	logic        ready;
	logic [63:0] result_value;

	modport source (output valid, result_value, input ready);
	modport sink   (input valid, result_value, output ready);
endinterface

>>> hdl/paillier_encrypt_decrypt_unit.sv
// ----------------------------------------------------------------------------
// paillier_encrypt_decrypt_unit
// Paillier encryption and decryption with the key in APB registers.
// ----------------------------------------------------------------------------
// One request at a time. Encrypt returns g^m * r^n mod n^2, decrypt returns
// L(c^lambda mod n^2) * mu mod n. All arithmetic runs through a single
// bit-serial unit: a division or reduction steps once per operand bit, and a
// modular product also spends an extra add step on each set multiplier bit.
// Each exponentiation walks 32 exponent bits with one squaring and, for a set
// bit, one multiply. A zero modulus answers 0 without using the serial unit.
// The request side takes a new transfer as soon as the sequencer is idle,
// while the previous result may still sit in the output register.
// Registers (64-bit data, byte address 8*i): 0 modulus, 1 generator,
// 2 lambda, 3 mu. Write only while no request is in flight.
// ----------------------------------------------------------------------------
module paillier_encrypt_decrypt_unit import pe_pkg::*; #(
	parameter int MOD_BITS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [63:0]       pwdata,
	output logic [63:0]       prdata,
	output logic              pready,
	pe_req_if.sink            req,
	pe_rsp_if.source          rsp
);

	// key registers
	logic [31:0] modulus_q;
	logic [63:0] generator_q;
	logic [31:0] lambda_q;
	logic [31:0] mu_q;

	logic [1:0] reg_idx;
	logic       wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[ADDR_W-1:3];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q   <= MODULUS_RST;
			generator_q <= GENERATOR_RST;
			lambda_q    <= LAMBDA_RST;
			mu_q        <= MU_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_MODULUS:   modulus_q   <= pwdata[31:0];
				REG_GENERATOR: generator_q <= pwdata;
				REG_LAMBDA:    lambda_q    <= pwdata[31:0];
				REG_MU:        mu_q        <= pwdata[31:0];
				default:       ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_MODULUS:   prdata = {32'd0, modulus_q};
			REG_GENERATOR: prdata = generator_q;
			REG_LAMBDA:    prdata = {32'd0, lambda_q};
			REG_MU:        prdata = {32'd0, mu_q};
			default:       prdata = '0;
		endcase
	end

	// only the low MOD_BITS bits of the modulus count
	logic [MOD_BITS-1:0] n;
	assign n = modulus_q[MOD_BITS-1:0];

	// sequencer and datapath registers
	state_t              st_q, st_n;
	state_t              ret_q, ret_n;    // where to go when the unit finishes
	state_t              pret_q;          // where to go when an exponentiation ends
	logic                cmd_q;
	logic [31:0]         msg_q;
	logic [31:0]         nonce_q;
	logic [63:0]         ctext_q;
	logic [WORD_W-1:0]   n2_q;
	logic [WORD_W-1:0]   base_q;
	logic [WORD_W-1:0]   rred_q;
	logic [WORD_W-1:0]   acc_q;
	logic [WORD_W-1:0]   p1_q;
	logic [EXP_BITS-1:0] exp_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [MOD_BITS-1:0] l_q;
	logic [63:0]         res_q;
	logic                out_valid_q;

	ser_ctl_t          ctl;
	ser_sts_t          sts;
	logic [WORD_W-1:0] opa, opb, opm;
	logic [WORD_W-1:0] u_res, u_quo;
	logic [WORD_W-1:0] acc_init;
	logic              out_free;
	logic              req_xfer;

	assign acc_init = (n2_q == WORD_W'(1)) ? '0 : WORD_W'(1);
	assign out_free = !out_valid_q || rsp.ready;
	assign req.ready = (st_q == ST_IDLE);
	assign req_xfer  = req.valid && req.ready;

	pe_serial_unit u_ser (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.opa    (opa),
		.opb    (opb),
		.opm    (opm),
		.sts    (sts),
		.res    (u_res),
		.quo    (u_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			st_q <= st_n;
		end
	end

	// next state and unit commands
	always_comb begin
		st_n      = st_q;
		ret_n     = ret_q;
		ctl.start = 1'b0;
		ctl.op    = OP_MUL;
		opa       = '0;
		opb       = '0;
		opm       = n2_q;
		case (st_q)
			ST_IDLE: begin
				if (req.valid) begin
					if (n == '0) begin
						st_n = ST_ZERO;
					end else begin
						// n^2 first
						ctl.start = 1'b1;
						ctl.op    = OP_MUL;
						opa       = WORD_W'(n);
						opb       = WORD_W'(n);
						ret_n     = ST_N2;
						st_n      = ST_WAIT;
					end
				end
			end
			ST_WAIT: begin
				if (sts.done) begin
					st_n = ret_q;
				end
			end
			ST_N2: begin
				// reduce g (encrypt) or c (decrypt) modulo n^2
				ctl.start = 1'b1;
				ctl.op    = OP_DIV;
				opb       = (cmd_q == CMD_DECRYPT) ? ctext_q : generator_q;
				opm       = u_res;
				ret_n     = (cmd_q == CMD_DECRYPT) ? ST_CRED : ST_GRED;
				st_n      = ST_WAIT;
			end
			ST_GRED: begin
				ctl.start = 1'b1;
				ctl.op    = OP_DIV;
				opb       = WORD_W'(nonce_q);
				ret_n     = ST_RRED;
				st_n      = ST_WAIT;
			end
			ST_RRED: st_n = ST_PSQ;
			ST_PSQ: begin
				ctl.start = 1'b1;
				ctl.op    = OP_MULMOD;
				opa       = acc_q;
				opb       = acc_q;
				ret_n     = ST_PSQD;
				st_n      = ST_WAIT;
			end
			ST_PSQD: st_n = ST_PMUL;
			ST_PMUL: begin
				if (exp_q[EXP_BITS-1]) begin
					ctl.start = 1'b1;
					ctl.op    = OP_MULMOD;
					opa       = acc_q;
					opb       = base_q;
					ret_n     = ST_PMULD;
					st_n      = ST_WAIT;
				end else begin
					st_n = ST_PSTEP;
				end
			end
			ST_PMULD: st_n = ST_PSTEP;
			ST_PSTEP: st_n = (cnt_q == CNT_W'(1)) ? pret_q : ST_PSQ;
			ST_E1:    st_n = ST_PSQ;
			ST_E2: begin
				ctl.start = 1'b1;
				ctl.op    = OP_MULMOD;
				opa       = p1_q;
				opb       = acc_q;
				ret_n     = ST_FIN;
				st_n      = ST_WAIT;
			end
			ST_CRED: st_n = ST_PSQ;
			ST_D1: begin
				if (acc_q == '0) begin
					st_n = ST_DMU;
				end else begin
					// L(x) = (x - 1) / n
					ctl.start = 1'b1;
					ctl.op    = OP_DIV;
					opb       = acc_q - WORD_W'(1);
					opm       = WORD_W'(n);
					ret_n     = ST_DL;
					st_n      = ST_WAIT;
				end
			end
			ST_DL: st_n = ST_DMU;
			ST_DMU: begin
				ctl.start = 1'b1;
				ctl.op    = OP_DIV;
				opb       = WORD_W'(mu_q);
				opm       = WORD_W'(n);
				ret_n     = ST_DMUR;
				st_n      = ST_WAIT;
			end
			ST_DMUR: begin
				ctl.start = 1'b1;
				ctl.op    = OP_MULMOD;
				opa       = WORD_W'(l_q);
				opb       = u_res;
				opm       = WORD_W'(n);
				ret_n     = ST_FIN;
				st_n      = ST_WAIT;
			end
			ST_FIN, ST_ZERO: begin
				if (out_free) begin
					st_n = ST_IDLE;
				end
			end
			default: st_n = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ret_q       <= ST_IDLE;
			pret_q      <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.start) begin
				ret_q <= ret_n;
			end
			// a new result replaces the one leaving in the same cycle
			if ((st_q inside {ST_FIN, ST_ZERO}) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.valid && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (st_q)
				ST_RRED, ST_E1, ST_CRED: cnt_q <= CNT_W'(EXP_BITS);
				ST_PSTEP:                cnt_q <= cnt_q - CNT_W'(1);
				default: ;
			endcase
			case (st_q)
				ST_RRED: pret_q <= ST_E1;
				ST_E1:   pret_q <= ST_E2;
				ST_CRED: pret_q <= ST_D1;
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (req_xfer) begin
			cmd_q   <= req.command;
			msg_q   <= req.plaintext;
			nonce_q <= req.nonce;
			ctext_q <= req.ciphertext;
		end
		case (st_q)
			ST_N2:   n2_q   <= u_res;
			ST_GRED: base_q <= u_res;
			ST_RRED: begin
				// first exponentiation: g^m
				rred_q <= u_res;
				acc_q  <= acc_init;
				exp_q  <= msg_q;
			end
			ST_PSQD, ST_PMULD: acc_q <= u_res;
			ST_PSTEP: exp_q <= {exp_q[EXP_BITS-2:0], 1'b0};
			ST_E1: begin
				// second exponentiation: r^n
				p1_q   <= acc_q;
				acc_q  <= acc_init;
				exp_q  <= EXP_BITS'(n);
				base_q <= rred_q;
			end
			ST_CRED: begin
				base_q <= u_res;
				acc_q  <= acc_init;
				exp_q  <= lambda_q;
			end
			ST_D1: begin
				// c not coprime to n: L is -1, that is n - 1
				if (acc_q == '0) begin
					l_q <= n - MOD_BITS'(1);
				end
			end
			ST_DL: l_q <= u_quo[MOD_BITS-1:0];
			ST_FIN: begin
				if (out_free) begin
					res_q <= u_res;
				end
			end
			ST_ZERO: begin
				if (out_free) begin
					res_q <= '0;
				end
			end
			default: ;
		endcase
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.result_value = res_q;

`ifndef SYNTH
	a_xfer_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req_xfer |=> (st_q != ST_IDLE))
		else $error("request transfer did not start the sequencer");

	a_start_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.start |-> !sts.busy)
		else $error("serial unit started while busy");

	a_wait_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_WAIT && !sts.done) |-> sts.busy)
		else $error("sequencer waits on an idle serial unit");

	a_load_only_free: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !rsp.ready) |=> $stable(res_q))
		else $error("pending result overwritten");
`endif

endmodule

>>> hdl/pe_serial_unit.sv
// ----------------------------------------------------------------------------
// pe_serial_unit
// Bit-serial arithmetic unit: product, modular product, division.
// ----------------------------------------------------------------------------
module pe_serial_unit import pe_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  ser_ctl_t          ctl,
	input  logic [WORD_W-1:0] opa,
	input  logic [WORD_W-1:0] opb,
	input  logic [WORD_W-1:0] opm,
	output ser_sts_t          sts,
	output logic [WORD_W-1:0] res,
	output logic [WORD_W-1:0] quo
);

	logic              busy_q;
	logic              done_q;
	logic              ph_q;     // 1: add cycle of a set multiplier bit
	op_t               op_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [WORD_W-1:0] a_q;
	logic [WORD_W-1:0] b_q;
	logic [WORD_W-1:0] m_q;
	logic [WORD_W-1:0] acc_q;
	logic [WORD_W-1:0] quo_q;

	logic [WORD_W-1:0] addend;
	logic [WORD_W:0]   sum;
	logic [WORD_W:0]   trial;
	logic [WORD_W+1:0] diff;
	logic              ge;
	logic [WORD_W-1:0] nxt_acc;
	logic              adv;

	always_comb begin
		addend = ph_q ? a_q : acc_q;
		sum    = {1'b0, acc_q} + {1'b0, addend};
		trial  = (op_q == OP_DIV) ? {acc_q, b_q[WORD_W-1]} : sum;
		diff   = {1'b0, trial} - {2'b00, m_q};
		ge     = ~diff[WORD_W+1];
		if (op_q == OP_MUL) begin
			nxt_acc = trial[WORD_W-1:0];
		end else begin
			nxt_acc = ge ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
		end
		// division takes one bit a cycle, products spend an extra add step on set bits
		adv = (op_q == OP_DIV) || ph_q || !b_q[WORD_W-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			ph_q   <= 1'b0;
			op_q   <= OP_MUL;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				ph_q   <= 1'b0;
				op_q   <= ctl.op;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (adv) begin
					ph_q  <= 1'b0;
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(WORD_W - 1)) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end
				end else begin
					ph_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			a_q   <= opa;
			b_q   <= opb;
			m_q   <= opm;
			acc_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			acc_q <= nxt_acc;
			if (op_q == OP_DIV) begin
				quo_q <= {quo_q[WORD_W-2:0], ge};
			end
			if (adv) begin
				b_q <= {b_q[WORD_W-2:0], 1'b0};
			end
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign res      = acc_q;
	assign quo      = quo_q;

endmodule
